>>> rtl/gcd_bm_pkg.sv
// gcd_bm_pkg: widths, word types and register indexes shared by the
// gcd coprocessor bus master, its channel interfaces and its top level.
// No dependencies.
package gcd_bm_pkg;

   localparam int DATA_W         = 32;
   localparam int OFFSET_W       = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int ADDR_WIDTH_DEF = 32;
   localparam int WORD_BYTES     = 4;

   typedef logic [DATA_W-1:0]      word_type;
   typedef logic [OFFSET_W-1:0]    offset_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes on the csr channel
   localparam csr_index_type CSR_BASE_ADDRESS  = csr_index_type'(0);
   localparam csr_index_type CSR_OPA_OFFSET    = csr_index_type'(1);
   localparam csr_index_type CSR_OPB_OFFSET    = csr_index_type'(2);
   localparam csr_index_type CSR_START_OFFSET  = csr_index_type'(3);
   localparam csr_index_type CSR_STATUS_OFFSET = csr_index_type'(4);

endpackage

>>> rtl/gcd_bm_req_if.sv
// gcd_bm_req_if: input channel, one word per clock tick of the initiator
// (bus handshakes, response data, fresh operands). Depends on gcd_bm_pkg.
interface gcd_bm_req_if import gcd_bm_pkg::*; ();

   logic     valid;
   logic     ready;
   logic     req_accepted;
   logic     rsp_valid;
   word_type rsp_data;
   word_type fresh_opa;
   word_type fresh_opb;

   modport source (
      output valid, req_accepted, rsp_valid, rsp_data, fresh_opa, fresh_opb,
      input  ready
   );

   modport sink (
      input  valid, req_accepted, rsp_valid, rsp_data, fresh_opa, fresh_opb,
      output ready
   );

endinterface

>>> rtl/gcd_bm_rsp_if.sv
// gcd_bm_rsp_if: result channel, one word per tick with the bus request
// outputs and the display fields. Depends on gcd_bm_pkg.
interface gcd_bm_rsp_if import gcd_bm_pkg::*; ();

   logic     valid;
   logic     ready;
   logic     req_valid;
   logic     req_write;
   word_type req_address;
   word_type req_wdata;
   logic     rsp_ready;
   logic     done_res;
   word_type shown_opa;
   word_type shown_opb;
   word_type shown_gcd;
   word_type iteration_count;
   word_type cycle_count;

   modport source (
      output valid, req_valid, req_write, req_address, req_wdata, rsp_ready,
             done_res, shown_opa, shown_opb, shown_gcd, iteration_count,
             cycle_count,
      input  ready
   );

   modport sink (
      input  valid, req_valid, req_write, req_address, req_wdata, rsp_ready,
             done_res, shown_opa, shown_opb, shown_gcd, iteration_count,
             cycle_count,
      output ready
   );

endinterface

>>> rtl/gcd_bm_csr_if.sv
// gcd_bm_csr_if: register write channel (index and write data).
// Depends on gcd_bm_pkg.
interface gcd_bm_csr_if import gcd_bm_pkg::*; ();

   logic          valid;
   logic          ready;
   csr_index_type index;
   word_type      wdata;

   modport source (
      output valid, index, wdata,
      input  ready
   );

   modport sink (
      input  valid, index, wdata,
      output ready
   );

endinterface

>>> rtl/gcd_coprocessor_bus_master.sv
// gcd_coprocessor_bus_master: command sequencer that drives a memory-mapped
// gcd coprocessor, one input word per tick. Depends on gcd_bm_pkg and the
// gcd_bm_req_if, gcd_bm_rsp_if and gcd_bm_csr_if interfaces.
//
//   channel   direction  handshake     carries
//   req_if    in         valid/ready   bus handshakes, read data, operands
//   rsp_if    out        valid/ready   bus request, display fields
//   csr_if    in         valid/ready   register index, write data
//
// one word per cycle sustained; an accepted word reaches the result through
// the input register, then the result register.
// the phase update and the address add sit between the two registers.
// reset clears the phase, counters and valid flags, and sets the register window to base 0 and offsets 0 to 3.
// a stall on rsp_if holds the result register and, once the input
// register is full too, drops req_if.ready.
// csr_if is always ready; a write to an unlisted index is dropped.
module gcd_coprocessor_bus_master import gcd_bm_pkg::*; #(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   gcd_bm_req_if.sink   req_if,
   gcd_bm_rsp_if.source rsp_if,
   gcd_bm_csr_if.sink   csr_if
);

   // phase codes
   localparam logic [3:0] PH_LOAD     = 4'd0;
   localparam logic [3:0] PH_CMD_A    = 4'd1;
   localparam logic [3:0] PH_RSP_A    = 4'd2;
   localparam logic [3:0] PH_CMD_B    = 4'd3;
   localparam logic [3:0] PH_RSP_B    = 4'd4;
   localparam logic [3:0] PH_CMD_GO   = 4'd5;
   localparam logic [3:0] PH_RSP_GO   = 4'd6;
   localparam logic [3:0] PH_CMD_POLL = 4'd7;
   localparam logic [3:0] PH_RSP_POLL = 4'd8;
   localparam logic [3:0] PH_CMD_RES  = 4'd9;
   localparam logic [3:0] PH_RSP_RES  = 4'd10;
   localparam logic [3:0] PH_SHOW     = 4'd11;

   // address window: byte address kept to ADDR_WIDTH bits, then to a word
   localparam int WORD_SHIFT = $clog2(WORD_BYTES);
   localparam int KEEP_W     = (ADDR_WIDTH < DATA_W) ? ADDR_WIDTH : DATA_W;
   localparam logic [DATA_W:0] MASK_WIDE =
      ({{DATA_W{1'b0}}, 1'b1} << KEEP_W) - {{DATA_W{1'b0}}, 1'b1};
   localparam word_type ADDR_MASK = MASK_WIDE[DATA_W-1:0];

   // register window
   word_type   base_address_ff;
   offset_type opa_offset_ff;
   offset_type opb_offset_ff;
   offset_type start_offset_ff;
   offset_type status_offset_ff;

   // input register
   logic     s1_valid_ff;
   logic     s1_accepted_ff;
   logic     s1_rsp_valid_ff;
   word_type s1_rsp_data_ff;
   word_type s1_fresh_opa_ff;
   word_type s1_fresh_opb_ff;

   // sequencer state
   logic [3:0] phase_ff, phase_in;
   word_type   operand_a_ff, operand_a_in;
   word_type   operand_b_ff, operand_b_in;
   word_type   gcd_value_ff, gcd_value_in;
   word_type   iterations_ff, iterations_in;
   word_type   ticks_ff;

   // result register
   logic     out_valid_ff;
   logic     o_req_valid_ff, o_req_valid_in;
   logic     o_req_write_ff, o_req_write_in;
   word_type o_req_address_ff, o_req_address_in;
   word_type o_req_wdata_ff, o_req_wdata_in;
   logic     o_rsp_ready_ff, o_rsp_ready_in;
   logic     o_done_ff, o_done_in;
   word_type o_shown_opa_ff, o_shown_opa_in;
   word_type o_shown_opb_ff, o_shown_opb_in;
   word_type o_shown_gcd_ff, o_shown_gcd_in;
   word_type o_iter_ff, o_iter_in;
   word_type o_cycle_ff, o_cycle_in;

   logic        step;
   logic        in_ready;
   offset_type  offset_sel;
   logic [DATA_W:0] addr_sum;
   word_type    window_addr;

   // pipeline handshake
   assign step     = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign in_ready = !s1_valid_ff || step;
   assign req_if.ready = in_ready;
   assign csr_if.ready = 1'b1;

   // register window writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff  <= '0;
         opa_offset_ff    <= offset_type'(0);
         opb_offset_ff    <= offset_type'(1);
         start_offset_ff  <= offset_type'(2);
         status_offset_ff <= offset_type'(3);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_BASE_ADDRESS:  base_address_ff  <= csr_if.wdata;
            CSR_OPA_OFFSET:    opa_offset_ff    <= csr_if.wdata[OFFSET_W-1:0];
            CSR_OPB_OFFSET:    opb_offset_ff    <= csr_if.wdata[OFFSET_W-1:0];
            CSR_START_OFFSET:  start_offset_ff  <= csr_if.wdata[OFFSET_W-1:0];
            CSR_STATUS_OFFSET: status_offset_ff <= csr_if.wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_if.valid) begin
         s1_accepted_ff  <= req_if.req_accepted;
         s1_rsp_valid_ff <= req_if.rsp_valid;
         s1_rsp_data_ff  <= req_if.rsp_data;
         s1_fresh_opa_ff <= req_if.fresh_opa;
         s1_fresh_opb_ff <= req_if.fresh_opb;
      end
   end

   // register offset for the phase, then base plus word offset
   always_comb begin
      case (phase_ff)
         PH_CMD_B:    offset_sel = opb_offset_ff;
         PH_CMD_GO:   offset_sel = start_offset_ff;
         PH_CMD_POLL: offset_sel = status_offset_ff;
         default:     offset_sel = opa_offset_ff;
      endcase
   end

   assign addr_sum    = {1'b0, base_address_ff}
                      + (DATA_W+1)'({offset_sel, {WORD_SHIFT{1'b0}}});
   assign window_addr = addr_sum[DATA_W-1:0] & ADDR_MASK;

   // moore outputs of the current phase
   always_comb begin
      o_req_valid_in   = 1'b0;
      o_req_write_in   = 1'b0;
      o_req_address_in = '0;
      o_req_wdata_in   = '0;
      o_done_in        = 1'b0;
      case (phase_ff)
         PH_CMD_A: begin
            o_req_valid_in   = 1'b1;
            o_req_write_in   = 1'b1;
            o_req_address_in = window_addr;
            o_req_wdata_in   = operand_a_ff;
         end
         PH_CMD_B: begin
            o_req_valid_in   = 1'b1;
            o_req_write_in   = 1'b1;
            o_req_address_in = window_addr;
            o_req_wdata_in   = operand_b_ff;
         end
         PH_CMD_GO: begin
            o_req_valid_in   = 1'b1;
            o_req_write_in   = 1'b1;
            o_req_address_in = window_addr;
         end
         PH_CMD_POLL, PH_CMD_RES: begin
            o_req_valid_in   = 1'b1;
            o_req_address_in = window_addr;
         end
         PH_SHOW: begin
            o_done_in = 1'b1;
         end
         default: ;
      endcase
      o_rsp_ready_in = phase_ff inside {PH_RSP_A, PH_RSP_B, PH_RSP_GO,
                                        PH_RSP_POLL, PH_RSP_RES};
      o_shown_opa_in = o_done_in ? operand_a_ff  : '0;
      o_shown_opb_in = o_done_in ? operand_b_ff  : '0;
      o_shown_gcd_in = o_done_in ? gcd_value_ff  : '0;
      o_iter_in      = o_done_in ? iterations_ff : '0;
      o_cycle_in     = o_done_in ? ticks_ff      : '0;
   end

   // phase transition for the word in the input register
   always_comb begin
      phase_in      = phase_ff;
      operand_a_in  = operand_a_ff;
      operand_b_in  = operand_b_ff;
      gcd_value_in  = gcd_value_ff;
      iterations_in = iterations_ff;
      case (phase_ff)
         PH_CMD_A:    if (s1_accepted_ff)  phase_in = PH_RSP_A;
         PH_RSP_A:    if (s1_rsp_valid_ff) phase_in = PH_CMD_B;
         PH_CMD_B:    if (s1_accepted_ff)  phase_in = PH_RSP_B;
         PH_RSP_B:    if (s1_rsp_valid_ff) phase_in = PH_CMD_GO;
         PH_CMD_GO:   if (s1_accepted_ff)  phase_in = PH_RSP_GO;
         PH_RSP_GO:   if (s1_rsp_valid_ff) phase_in = PH_CMD_POLL;
         PH_CMD_POLL: if (s1_accepted_ff)  phase_in = PH_RSP_POLL;
         PH_RSP_POLL: begin
            if (s1_rsp_valid_ff) begin
               phase_in = (s1_rsp_data_ff == '0) ? PH_CMD_RES : PH_CMD_POLL;
            end
         end
         PH_CMD_RES:  if (s1_accepted_ff)  phase_in = PH_RSP_RES;
         PH_RSP_RES: begin
            if (s1_rsp_valid_ff) begin
               gcd_value_in = s1_rsp_data_ff;
               phase_in     = PH_SHOW;
            end
         end
         PH_SHOW:     phase_in = PH_LOAD;
         // load state, and any unused code behaves as load
         default: begin
            iterations_in = iterations_ff + 1'b1;
            operand_a_in  = s1_fresh_opa_ff;
            operand_b_in  = s1_fresh_opb_ff;
            phase_in      = PH_CMD_A;
         end
      endcase
   end

   // sequencer state, advanced once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LOAD;
         gcd_value_ff  <= '0;
         iterations_ff <= '0;
         ticks_ff      <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         gcd_value_ff  <= gcd_value_in;
         iterations_ff <= iterations_in;
         ticks_ff      <= ticks_ff + 1'b1;
      end
   end

   // operands have no reset value, they are loaded before first use
   always_ff @(posedge clock) begin
      if (step) begin
         operand_a_ff <= operand_a_in;
         operand_b_ff <= operand_b_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         o_req_valid_ff   <= o_req_valid_in;
         o_req_write_ff   <= o_req_write_in;
         o_req_address_ff <= o_req_address_in;
         o_req_wdata_ff   <= o_req_wdata_in;
         o_rsp_ready_ff   <= o_rsp_ready_in;
         o_done_ff        <= o_done_in;
         o_shown_opa_ff   <= o_shown_opa_in;
         o_shown_opb_ff   <= o_shown_opb_in;
         o_shown_gcd_ff   <= o_shown_gcd_in;
         o_iter_ff        <= o_iter_in;
         o_cycle_ff       <= o_cycle_in;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.req_valid       = o_req_valid_ff;
   assign rsp_if.req_write       = o_req_write_ff;
   assign rsp_if.req_address     = o_req_address_ff;
   assign rsp_if.req_wdata       = o_req_wdata_ff;
   assign rsp_if.rsp_ready       = o_rsp_ready_ff;
   assign rsp_if.done_res        = o_done_ff;
   assign rsp_if.shown_opa       = o_shown_opa_ff;
   assign rsp_if.shown_opb       = o_shown_opb_ff;
   assign rsp_if.shown_gcd       = o_shown_gcd_ff;
   assign rsp_if.iteration_count = o_iter_ff;
   assign rsp_if.cycle_count     = o_cycle_ff;

   // state only moves when a word leaves the input register
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(ticks_ff) && $stable(iterations_ff))
      else $error("sequencer state changed without a word");

   // every word advances the tick counter by one
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      step |=> ticks_ff == $past(ticks_ff) + 1'b1)
      else $error("tick counter skipped or stuck");

   // a load counts one iteration and starts the operand A write
   a_load_step: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_LOAD |=>
         phase_ff == PH_CMD_A && iterations_ff == $past(iterations_ff) + 1'b1)
      else $error("load step did not start an iteration");

   // input back-pressure only when the input register is held
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> s1_valid_ff && out_valid_ff && !rsp_if.ready)
      else $error("input stalled with room in the pipeline");

   // a done word carries the display fields, others carry zeros
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff != PH_SHOW |=> !o_done_ff && o_shown_gcd_ff == '0)
      else $error("display fields set outside the display state");

endmodule
